>>> rtl/atma_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the tilt-angle
// moving-average block. No dependencies.
package atma_pkg;

    localparam int WINDOW_LEN_DEF = 20;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 17;
    localparam int SQ_W      = 32;
    localparam int N_W       = 62;
    localparam int ROOT_W    = 31;
    localparam int SREM_W    = 33;
    localparam int CORD_W    = 34;
    localparam int ACC_W     = 24;
    localparam int STEP_W    = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam int SQRT_STEPS   = 31;
    localparam int CORDIC_STEPS = 20;
    localparam int ANGLE_LIMIT  = 23040;
    localparam int CORR_LIMIT   = 46080;

    // register index is paddr[2]
    localparam logic REG_ANGLE_OFFSET = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_Y,
        S_SQ_Z,
        S_SQRT,
        S_CINIT,
        S_CORDIC,
        S_ROUND,
        S_UPDATE,
        S_DINIT,
        S_DIV,
        S_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_Y,
        OP_SQ_Z,
        OP_SQRT,
        OP_CINIT,
        OP_CORDIC,
        OP_ROUND,
        OP_UPDATE,
        OP_DINIT,
        OP_DIV,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        logic [STEP_W-1:0]  step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_sts_t;

    // atan(2^-i) in degrees, scaled by 65536
    function automatic logic [ACC_W-2:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic [ACC_W-2:0] v;
        begin
            case (idx)
                5'd0:    v = 23'd2949120;
                5'd1:    v = 23'd1740967;
                5'd2:    v = 23'd919879;
                5'd3:    v = 23'd466945;
                5'd4:    v = 23'd234379;
                5'd5:    v = 23'd117304;
                5'd6:    v = 23'd58666;
                5'd7:    v = 23'd29335;
                5'd8:    v = 23'd14668;
                5'd9:    v = 23'd7334;
                5'd10:   v = 23'd3667;
                5'd11:   v = 23'd1833;
                5'd12:   v = 23'd917;
                5'd13:   v = 23'd458;
                5'd14:   v = 23'd229;
                5'd15:   v = 23'd115;
                5'd16:   v = 23'd57;
                5'd17:   v = 23'd29;
                5'd18:   v = 23'd14;
                5'd19:   v = 23'd7;
                default: v = 23'd0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/accel_tilt_moving_average_core.sv
// Tilt angle from one accelerometer word, offset-corrected, averaged over a ring.
// Each word passes load, squares, square root, CORDIC, round, window update and divide to out_valid.
// One word is in flight at a time; the sequencer holds until the previous result is taken as the output
// drains; the next word is taken while a result waits.
// The cycle count is set by the 31-step square root, 20 CORDIC steps and the bit-serial divide.
// Reset (rst_n, async low) clears the offset, fill count, write slot and running sum.
module accel_tilt_moving_average_core
    import atma_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [IN_W-1:0]            accel_x,
    input  logic signed [IN_W-1:0]            accel_y,
    input  logic signed [IN_W-1:0]            accel_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [OUT_W-1:0]           avg_angle,
    output logic [$clog2(WINDOW_LEN + 1)-1:0] filled_count,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [PADDR_W-1:0]                paddr,
    input  logic [PDATA_W-1:0]                pwdata,
    output logic [PDATA_W-1:0]                prdata,
    output logic                              pready
);

    logic signed [IN_W-1:0] offset_reg;
    dp_cmd_t                cmd;
    dp_sts_t                sts;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_ANGLE_OFFSET)
        begin
            offset_reg <= pwdata[IN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ANGLE_OFFSET) ? PDATA_W'(offset_reg) : '0;

    atma_ctrl #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    atma_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .angle_offset (offset_reg),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .avg_angle    (avg_angle),
        .filled_count (filled_count)
    );

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (filled_count != '0 &&
                       filled_count <= ($clog2(WINDOW_LEN + 1))'(WINDOW_LEN)))
        else $error("filled_count out of range");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (avg_angle <= (OUT_W)'(CORR_LIMIT) &&
                       avg_angle >= -((OUT_W)'(CORR_LIMIT))))
        else $error("avg_angle out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken while busy");

endmodule

>>> rtl/atma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module atma_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 20
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/atma_ctrl.sv
// Sequencer for the tilt-angle block: walks squares, square root, CORDIC,
// window update and divide. Uses atma_pkg; drives atma_dp by command struct.
module atma_ctrl
    import atma_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam int TOT_W = $clog2(CORR_LIMIT * WINDOW_LEN + 1) + 1;
    localparam int MAG_W = TOT_W - 1;

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.step   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SQ_Y;
                end
            end
            S_SQ_Y:
            begin
                cmd.op     = OP_SQ_Y;
                state_next = S_SQ_Z;
            end
            S_SQ_Z:
            begin
                cmd.op     = OP_SQ_Z;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_CINIT;
                end
            end
            S_CINIT:
            begin
                cmd.op     = OP_CINIT;
                cnt_next   = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.op   = OP_CORDIC;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.op     = OP_ROUND;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.op     = OP_UPDATE;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.op     = OP_DINIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(MAG_W - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register frees up
                if (!sts.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/atma_dp.sv
// Datapath: squares, bit-pair square root, CORDIC vectoring, window ring and
// running sum, restoring divider, output register. Uses atma_pkg, atma_ram.
module atma_dp
    import atma_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [IN_W-1:0]               accel_x,
    input  logic signed [IN_W-1:0]               accel_y,
    input  logic signed [IN_W-1:0]               accel_z,
    input  logic signed [IN_W-1:0]               angle_offset,
    input  dp_cmd_t                              cmd,
    output dp_sts_t                              sts,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [OUT_W-1:0]              avg_angle,
    output logic [$clog2(WINDOW_LEN + 1)-1:0]    filled_count
);

    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SLOT_W = WINDOW_LEN > 1 ? $clog2(WINDOW_LEN) : 1;
    localparam int TOT_W  = $clog2(CORR_LIMIT * WINDOW_LEN + 1) + 1;
    localparam int MAG_W  = TOT_W - 1;

    localparam logic signed [ACC_W-1:0] ANG_MAX  = ACC_W'(ANGLE_LIMIT);
    localparam logic signed [OUT_W:0]   CORR_MAX = (OUT_W + 1)'(CORR_LIMIT);
    localparam logic signed [OUT_W:0]   CORR_MIN = -((OUT_W + 1)'(CORR_LIMIT));

    logic signed [IN_W-1:0]   x_reg, y_reg, z_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [N_W-1:0]           n_reg;
    logic [SREM_W-1:0]        srem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic signed [CORD_W-1:0] cx_reg, cy_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [OUT_W-1:0]  corr_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic signed [TOT_W-1:0]  total_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         q_reg;
    logic [CNT_W-1:0]         drem_reg;
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  avg_reg;
    logic [CNT_W-1:0]         fcnt_reg;

    // squares, one multiplier shared by the y and z squares
    logic signed [IN_W-1:0]   mul_a;
    logic signed [SQ_W-1:0]   prod;
    logic [SQ_W-1:0]          sq_sum;

    assign mul_a  = (cmd.op == OP_SQ_Y) ? y_reg : z_reg;
    assign prod   = mul_a * mul_a;
    assign sq_sum = sq_reg + SQ_W'($unsigned(prod));

    // square root, two radicand bits per step
    logic [SREM_W+1:0] s_cand, s_trial;
    logic              s_ge;

    assign s_cand  = {srem_reg, n_reg[N_W-1:N_W-2]};
    assign s_trial = {2'b00, root_reg, 2'b01};
    assign s_ge    = s_cand >= s_trial;

    // CORDIC vectoring step
    logic signed [CORD_W-1:0] dx, dy;
    logic signed [ACC_W-1:0]  atan_v;
    logic [IN_W:0]            ax;

    assign dx     = cy_reg >>> cmd.step;
    assign dy     = cx_reg >>> cmd.step;
    assign atan_v = $signed({1'b0, atan_lut(cmd.step)});
    assign ax     = x_reg[IN_W-1] ? -((IN_W + 1)'(x_reg)) : (IN_W + 1)'(x_reg);

    // round, clamp, sign, offset correction
    logic signed [ACC_W-1:0] ang_raw, ang_clip;
    logic signed [OUT_W:0]   ang_s, corr_w;
    logic signed [OUT_W-1:0] corr_sat;

    always_comb
    begin
        ang_raw = (acc_reg + ACC_W'(128)) >>> 8;
        if (ang_raw < 0)
        begin
            ang_clip = '0;
        end
        else if (ang_raw > ANG_MAX)
        begin
            ang_clip = ANG_MAX;
        end
        else
        begin
            ang_clip = ang_raw;
        end
        if (root_reg == '0)
        begin
            ang_clip = ANG_MAX;
        end
        if (x_reg == '0)
        begin
            ang_s = '0;
        end
        else if (!x_reg[IN_W-1])
        begin
            ang_s = -((OUT_W + 1)'(ang_clip));
        end
        else
        begin
            ang_s = (OUT_W + 1)'(ang_clip);
        end
        corr_w = ang_s - (OUT_W + 1)'(angle_offset);
        if (corr_w > CORR_MAX)
        begin
            corr_sat = OUT_W'(CORR_MAX);
        end
        else if (corr_w < CORR_MIN)
        begin
            corr_sat = OUT_W'(CORR_MIN);
        end
        else
        begin
            corr_sat = OUT_W'(corr_w);
        end
    end

    // window ring
    logic                    ring_we, ring_re;
    logic [OUT_W-1:0]        ring_rdata;
    logic                    full;
    logic signed [TOT_W-1:0] old_val, total_new;

    assign ring_re   = cmd.op == OP_ROUND;
    assign ring_we   = cmd.op == OP_UPDATE;
    assign full      = fill_reg == CNT_W'(WINDOW_LEN);
    assign old_val   = full ? TOT_W'($signed(ring_rdata)) : '0;
    assign total_new = total_reg + TOT_W'(corr_reg) - old_val;

    atma_ram #(
        .WIDTH (OUT_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (slot_reg),
        .wdata (corr_reg),
        .re    (ring_re),
        .raddr (slot_reg),
        .rdata (ring_rdata)
    );

    // restoring divider, one quotient bit per step
    logic [CNT_W:0]          d_cand;
    logic                    d_ge;
    logic signed [TOT_W-1:0] avg_wide;

    assign d_cand   = {drem_reg, q_reg[MAG_W-1]};
    assign d_ge     = d_cand >= {1'b0, fill_reg};
    assign avg_wide = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_UPDATE)
            begin
                total_reg <= total_new;
                if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (slot_reg == SLOT_W'(WINDOW_LEN - 1))
                begin
                    slot_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                x_reg <= accel_x;
                y_reg <= accel_y;
                z_reg <= accel_z;
            end
            OP_SQ_Y:
            begin
                sq_reg <= SQ_W'($unsigned(prod));
            end
            OP_SQ_Z:
            begin
                n_reg    <= {sq_sum, 30'd0};
                srem_reg <= '0;
                root_reg <= '0;
            end
            OP_SQRT:
            begin
                n_reg <= {n_reg[N_W-3:0], 2'b00};
                if (s_ge)
                begin
                    srem_reg <= SREM_W'(s_cand - s_trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= SREM_W'(s_cand);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            OP_CINIT:
            begin
                cx_reg  <= $signed(CORD_W'(root_reg));
                cy_reg  <= $signed(CORD_W'(ax) << 15);
                acc_reg <= '0;
            end
            OP_CORDIC:
            begin
                if (!cy_reg[CORD_W-1])
                begin
                    cx_reg  <= cx_reg + dx;
                    cy_reg  <= cy_reg - dy;
                    acc_reg <= acc_reg + atan_v;
                end
                else
                begin
                    cx_reg  <= cx_reg - dx;
                    cy_reg  <= cy_reg + dy;
                    acc_reg <= acc_reg - atan_v;
                end
            end
            OP_ROUND:
            begin
                corr_reg <= corr_sat;
            end
            OP_DINIT:
            begin
                neg_reg  <= total_reg[TOT_W-1];
                q_reg    <= total_reg[TOT_W-1] ? MAG_W'(-total_reg) : MAG_W'(total_reg);
                drem_reg <= '0;
            end
            OP_DIV:
            begin
                if (d_ge)
                begin
                    drem_reg <= CNT_W'(d_cand - {1'b0, fill_reg});
                    q_reg    <= {q_reg[MAG_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= CNT_W'(d_cand);
                    q_reg    <= {q_reg[MAG_W-2:0], 1'b0};
                end
            end
            OP_OUT:
            begin
                avg_reg  <= avg_wide[OUT_W-1:0];
                fcnt_reg <= fill_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.out_busy = out_valid_reg & ~out_ready;
    assign out_valid    = out_valid_reg;
    assign avg_angle    = avg_reg;
    assign filled_count = fcnt_reg;

endmodule
